[rtl/spr_pkg.sv]
// spr_pkg: shared types and constants for the stream pattern replace block
// used by spr_cfg_regs, spr_datapath, spr_ctrl and stream_pattern_replace
package spr_pkg;

  // sizes of pattern and replacement
  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int BYTE_W          = 8;
  localparam int WORD_W          = 64;
  localparam int LEN_W           = 4;
  localparam int PEND_IDX_W      = $clog2(MAX_PATTERN);
  localparam int REP_IDX_W       = $clog2(MAX_REPLACEMENT);
  localparam int REG_IDX_W       = 2;

  // register indexes of the write port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_BYTES,
    REG_PATTERN_LENGTH,
    REG_REPLACEMENT_BYTES,
    REG_REPLACEMENT_LENGTH
  } reg_index_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_REPL,
    ST_FLUSH,
    ST_EMPTY
  } state_t;

  // configuration with lengths already clamped to their legal range
  typedef struct packed {
    logic [WORD_W-1:0] pattern;
    logic [LEN_W-1:0]  pat_len;
    logic [WORD_W-1:0] repl;
    logic [LEN_W-1:0]  repl_len;
  } spr_cfg_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic emit_head;
    logic emit_repl;
    logic emit_empty;
    logic clear_count;
    logic rep_start;
    logic out_last;
  } spr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic prefix;
    logic full;
    logic n_zero;
    logic n_one;
    logic rep_last;
    logic rlen_zero;
    logic last;
    logic out_free;
  } spr_status_t;

endpackage

[rtl/spr_cfg_regs.sv]
// spr_cfg_regs: configuration registers written through the plain write port
// depends on spr_pkg for the register index codes and the config struct
module spr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [spr_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [spr_pkg::WORD_W-1:0]     wr_data,
  output spr_pkg::spr_cfg_t              cfg
);
  import spr_pkg::*;

  logic [WORD_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]  pattern_length;
  logic [WORD_W-1:0] replacement_bytes;
  logic [LEN_W-1:0]  replacement_length;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_PATTERN_BYTES:      pattern_bytes      <= wr_data;
        REG_PATTERN_LENGTH:     pattern_length     <= wr_data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= wr_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= wr_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp lengths: empty pattern counts as one byte, both saturate at max
  always_comb begin
    cfg.pattern = pattern_bytes;
    cfg.repl    = replacement_bytes;
    if (pattern_length == '0) begin
      cfg.pat_len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      cfg.pat_len = LEN_W'(MAX_PATTERN);
    end else begin
      cfg.pat_len = pattern_length;
    end
    if (replacement_length > LEN_W'(MAX_REPLACEMENT)) begin
      cfg.repl_len = LEN_W'(MAX_REPLACEMENT);
    end else begin
      cfg.repl_len = replacement_length;
    end
  end

endmodule

[rtl/spr_datapath.sv]
// spr_datapath: pending byte buffer, prefix compare, replacement index, output register
// depends on spr_pkg; driven by commands from spr_ctrl
module spr_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  spr_pkg::spr_cfg_t            cfg,
  input  spr_pkg::spr_cmd_t            cmd,
  output spr_pkg::spr_status_t         st,
  input  logic [spr_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         in_last,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [spr_pkg::BYTE_W-1:0]   m_tdata,
  output logic                         m_tlast,
  output logic                         m_tuser
);
  import spr_pkg::*;

  logic [BYTE_W-1:0]    pend [MAX_PATTERN];
  logic [LEN_W-1:0]     count;
  logic [WORD_W-1:0]    act_pattern;
  logic [LEN_W-1:0]     act_len;
  logic                 last;
  logic [REP_IDX_W-1:0] rep_idx;
  logic                 match_all;
  logic [BYTE_W-1:0]    repl_byte;

  // pending buffer: append on accept, drop the oldest byte on head emission
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend[count[PEND_IDX_W-1:0]] <= in_byte;
    end else if (cmd.emit_head) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        pend[i] <= pend[i+1];
      end
    end
  end

  // pending count, latched pattern and last flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      act_pattern <= '0;
      act_len     <= LEN_W'(1);
      last        <= 1'b0;
    end else begin
      if (cmd.accept) begin
        count <= count + LEN_W'(1);
        last  <= in_last;
        if (count == '0) begin
          act_pattern <= cfg.pattern;
          act_len     <= cfg.pat_len;
        end
      end else if (cmd.clear_count) begin
        count <= '0;
      end else if (cmd.emit_head) begin
        count <= count - LEN_W'(1);
      end
    end
  end

  // replacement byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_idx <= '0;
    end else if (cmd.rep_start) begin
      rep_idx <= '0;
    end else if (cmd.emit_repl) begin
      rep_idx <= rep_idx + REP_IDX_W'(1);
    end
  end

  // prefix compare of the pending bytes against the latched pattern
  always_comb begin
    match_all = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LEN_W'(i) < count) && (pend[i] != act_pattern[BYTE_W*i +: BYTE_W])) begin
        match_all = 1'b0;
      end
    end
  end

  assign repl_byte = cfg.repl[{rep_idx, 3'b000} +: BYTE_W];

  // status to the controller
  always_comb begin
    st.prefix    = match_all && (count <= act_len);
    st.full      = (count == act_len);
    st.n_zero    = (count == '0);
    st.n_one     = (count == LEN_W'(1));
    st.rep_last  = ((LEN_W'(rep_idx) + LEN_W'(1)) == cfg.repl_len);
    st.rlen_zero = (cfg.repl_len == '0);
    st.last      = last;
    st.out_free  = !m_tvalid || m_tready;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_head || cmd.emit_repl || cmd.emit_empty) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_head) begin
      m_tdata <= pend[0];
      m_tlast <= cmd.out_last;
      m_tuser <= 1'b0;
    end else if (cmd.emit_repl) begin
      m_tdata <= repl_byte;
      m_tlast <= cmd.out_last;
      m_tuser <= 1'b0;
    end else if (cmd.emit_empty) begin
      m_tdata <= '0;
      m_tlast <= cmd.out_last;
      m_tuser <= 1'b1;
    end
  end

  // pending bytes never outgrow the latched pattern
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= act_len)
    else $error("pending count exceeds pattern length");

  // a new word is loaded only when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_head || cmd.emit_repl || cmd.emit_empty) |-> (!m_tvalid || m_tready))
    else $error("output word overwritten");

  // head emission needs a pending byte
  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_head |-> (count != '0))
    else $error("head emitted from empty buffer");

endmodule

[rtl/spr_ctrl.sv]
// spr_ctrl: state machine sequencing accept, retry, replacement, flush and empty close
// depends on spr_pkg; talks to spr_datapath through command and status structs
module spr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  spr_pkg::spr_status_t  st,
  output spr_pkg::spr_cmd_t     cmd
);
  import spr_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!st.prefix) begin
          // not a prefix: emit the oldest byte and retry the rest
          if (st.out_free) begin
            cmd.emit_head = 1'b1;
            cmd.out_last  = st.last && st.n_one;
            if (st.n_one) begin
              state_next = ST_IDLE;
            end
          end
        end else if (st.full) begin
          // whole pattern seen
          cmd.clear_count = 1'b1;
          if (!st.rlen_zero) begin
            cmd.rep_start = 1'b1;
            state_next    = ST_REPL;
          end else if (st.last) begin
            state_next = ST_EMPTY;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (st.last && !st.n_zero) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_REPL: begin
        if (st.out_free) begin
          cmd.emit_repl = 1'b1;
          cmd.out_last  = st.last && st.rep_last;
          if (st.rep_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (st.out_free) begin
          cmd.emit_head = 1'b1;
          cmd.out_last  = st.n_one;
          if (st.n_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (st.out_free) begin
          cmd.emit_empty = 1'b1;
          cmd.out_last   = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // at most one word is produced per cycle
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_head, cmd.emit_repl, cmd.emit_empty}))
    else $error("several words emitted in one cycle");

  // replacement runs only with the pending buffer cleared
  a_repl_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPL) |-> st.n_zero)
    else $error("replacement with pending bytes");

  // flush happens only on the last byte with bytes pending
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (st.last && !st.n_zero))
    else $error("flush outside end of text");

endmodule

[rtl/stream_pattern_replace.sv]
// stream_pattern_replace: the first result word is loaded into the output register by EVAL
// when evaluation retries a byte, by REPL, FLUSH or EMPTY when one of those comes first
// per byte: an accept in IDLE, an EVAL step per retried byte plus a closing one unless the
// retries empty the buffer, then a REPL, FLUSH or EMPTY step per replacement, flushed or
// empty word; no new byte is taken before that, and a full output register stalls a step
// synchronous reset: idle controller, empty buffer, output invalid, registers at reset values
module stream_pattern_replace (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [spr_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [spr_pkg::WORD_W-1:0]    wr_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] in_byte
  input  logic                          s_tlast,   // in_last
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] out_byte
  output logic                          m_tlast,   // out_last
  output logic                          m_tuser    // [0] out_empty
);
  import spr_pkg::*;

  spr_cfg_t    cfg;
  spr_cmd_t    cmd;
  spr_status_t st;

  // configuration registers
  spr_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // controller
  spr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath
  spr_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .st       (st),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

[dv/stream_pattern_replace_tb.sv]
// stream_pattern_replace_tb: self-checking bench for the streaming find and replace block
// predicts rewritten words at input acceptance and checks them in order at the output
// depends on spr_pkg and stream_pattern_replace from the rtl folder
module stream_pattern_replace_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spr_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  // one input word and one output word
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } text_word_t;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             wr_en    = 1'b0;
  reg_index_t       wr_index = REG_PATTERN_BYTES;
  logic [WORD_W-1:0] wr_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata  = 8'h00;  // [7:0] in_byte
  logic             s_tlast  = 1'b0;   // in_last
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;           // [7:0] out_byte
  logic             m_tlast;           // out_last
  logic             m_tuser;           // [0] out_empty

  stream_pattern_replace uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // bench copy of the registers, reset values
  logic [63:0] cfg_pattern  = '0;
  logic [3:0]  cfg_pat_len  = 4'd1;
  logic [63:0] cfg_repl     = '0;
  logic [3:0]  cfg_repl_len = 4'd0;

  // predictor state: bytes of a partial match and the latched pattern
  logic [7:0]  held_bytes [MAX_PATTERN];
  int          held_count   = 0;
  logic [63:0] live_pattern = '0;
  int          live_len     = 1;

  text_byte_t text_q[$];
  text_word_t rewritten_q[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int error_count   = 0;
  int quiet_cycles  = 0;
  text_byte_t next_byte;

  initial begin
    foreach (held_bytes[i]) held_bytes[i] = 8'h00;
  end

  // expected words for one accepted input byte
  function automatic void predict_rewrite(input logic [7:0] in_byte, input logic in_last);
    logic [7:0] window[$];
    logic [7:0] emitted[$];
    text_word_t w;
    int keep;
    int rlen;
    int i;
    bit is_prefix;
    bit searching;
    if (held_count == 0) begin
      live_pattern = cfg_pattern;
      live_len = (cfg_pat_len == 0) ? 1 :
                 (cfg_pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_pat_len);
    end
    keep = (held_count > MAX_PATTERN - 1) ? MAX_PATTERN - 1 : held_count;
    for (i = 0; i < keep; i++) window.push_back(held_bytes[i]);
    window.push_back(in_byte);
    // drop the oldest byte until the window is a pattern prefix again
    searching = 1'b1;
    while (searching && window.size() > 0) begin
      is_prefix = (window.size() <= live_len);
      for (i = 0; i < window.size() && is_prefix; i++)
        if (window[i] != live_pattern[8*i +: 8]) is_prefix = 1'b0;
      if (is_prefix) searching = 1'b0;
      else emitted.push_back(window.pop_front());
    end
    // full match: replacement from the current registers
    if (window.size() == live_len) begin
      rlen = (cfg_repl_len > MAX_REPLACEMENT) ? MAX_REPLACEMENT : int'(cfg_repl_len);
      for (i = 0; i < rlen; i++) emitted.push_back(cfg_repl[8*i +: 8]);
      window.delete();
    end
    // end of text flushes the partial match
    if (in_last) begin
      while (window.size() > 0) emitted.push_back(window.pop_front());
    end
    held_count = window.size();
    for (i = 0; i < MAX_PATTERN; i++) held_bytes[i] = (i < window.size()) ? window[i] : 8'h00;
    if (in_last && emitted.size() == 0) begin
      w.data = 8'h00;
      w.last = 1'b1;
      w.empty = 1'b1;
      rewritten_q.push_back(w);
    end else begin
      for (i = 0; i < emitted.size(); i++) begin
        w.data = emitted[i];
        w.last = in_last && (i == emitted.size() - 1);
        w.empty = 1'b0;
        rewritten_q.push_back(w);
      end
    end
  endfunction

  // input driver, fed from text_q
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (text_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = text_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= next_byte.data;
        s_tlast <= next_byte.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: predict on input words, check output words in order
  always @(posedge clk) begin
    text_word_t got;
    text_word_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_rewrite(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got.data = m_tdata;
        got.last = m_tlast;
        got.empty = m_tuser;
        if (rewritten_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected word data %h last %b empty %b",
                     $realtime, got.data, got.last, got.empty);
        end else begin
          want = rewritten_q.pop_front();
          if (got != want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display({"%0t: mismatch expected data %h last %b empty %b, ",
                        "got data %h last %b empty %b"},
                       $realtime, want.data, want.last, want.empty,
                       got.data, got.last, got.empty);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // write all four registers back to back; call only while idle, the task does not check it
  task automatic write_config(input logic [63:0] pat, input logic [3:0] plen,
                              input logic [63:0] repl, input logic [3:0] rlen);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= REG_PATTERN_BYTES;
    wr_data <= pat;
    @(posedge clk);
    wr_index <= REG_PATTERN_LENGTH;
    wr_data <= {60'd0, plen};
    @(posedge clk);
    wr_index <= REG_REPLACEMENT_BYTES;
    wr_data <= repl;
    @(posedge clk);
    wr_index <= REG_REPLACEMENT_LENGTH;
    wr_data <= {60'd0, rlen};
    @(posedge clk);
    wr_en <= 1'b0;
    cfg_pattern = pat;
    cfg_pat_len = plen;
    cfg_repl = repl;
    cfg_repl_len = rlen;
  endtask

  task automatic queue_text(input logic [7:0] bytes[$], input bit close);
    text_byte_t t;
    int i;
    for (i = 0; i < bytes.size(); i++) begin
      t.data = bytes[i];
      t.last = close && (i == bytes.size() - 1);
      text_q.push_back(t);
    end
  endtask

  // wait until every word is accepted and every expected word has come out
  task automatic drain();
    while (text_q.size() != 0 || s_tvalid || rewritten_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // texts built mostly from pattern pieces, some broken matches, replacement bytes and noise
  task automatic queue_random_texts(input int budget, input bit leave_open);
    logic [7:0] text[$];
    int plen;
    int produced;
    int kind;
    int n;
    int k;
    plen = (cfg_pat_len == 0) ? 1 :
           (cfg_pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_pat_len);
    produced = 0;
    while (produced < budget) begin
      text.delete();
      repeat ($urandom_range(1, 6)) begin
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
          for (k = 0; k < plen; k++) text.push_back(cfg_pattern[8*k +: 8]);
        end else if (kind <= 5) begin
          n = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
          for (k = 0; k < n; k++) text.push_back(cfg_pattern[8*k +: 8]);
        end else if (kind <= 7) begin
          repeat ($urandom_range(1, 3)) begin
            k = $urandom_range(0, plen - 1);
            text.push_back($urandom_range(1) ? cfg_pattern[8*k +: 8] : 8'($urandom));
          end
        end else if (kind == 8) begin
          repeat ($urandom_range(1, 3)) begin
            k = $urandom_range(0, 7);
            text.push_back(cfg_repl[8*k +: 8]);
          end
        end else begin
          repeat ($urandom_range(1, 4)) text.push_back(8'($urandom));
        end
      end
      queue_text(text, !(leave_open && produced + text.size() >= budget));
      produced += text.size();
    end
  endtask

  initial begin
    logic [63:0] pat;
    logic [63:0] repl;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    int phase;
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: single zero byte deleted, text closes with an empty word
    queue_text('{8'h00}, 1'b1);
    queue_text('{8'hFF, 8'h80}, 1'b1);
    drain();

    // self-overlapping pattern forces a retry, then a partial match is flushed
    write_config(64'h0000_0000_0062_6161, 4'd3, 64'h0000_0000_0000_5958, 4'd2);
    queue_text('{8'h61, 8'h61, 8'h61, 8'h62, 8'h61, 8'h61}, 1'b1);
    drain();

    // longest pattern and replacement, then leave a partial match open
    write_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0123_4567_89AB_CDEF, 4'd8);
    queue_text('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1);
    queue_text('{8'hFF, 8'hFF}, 1'b0);
    drain();

    // pattern changed mid-match: old match completes, new replacement applies,
    // zero pattern length acts as one, oversize replacement length saturates
    write_config(64'h0000_0000_0000_005A, 4'd0, 64'hFEDC_BA98_7654_3210, 4'd15);
    queue_text('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A, 8'h5A}, 1'b1);
    drain();

    // random phases: no idling, sender idle, receiver stalls, both
    for (phase = 0; phase < 12; phase++) begin
      case (phase / 3)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      k = $urandom_range(0, 9);
      plen = (k == 0) ? 4'($urandom_range(9, 15)) : (k == 1) ? 4'd0 : 4'($urandom_range(1, 8));
      k = $urandom_range(0, 9);
      rlen = (k == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      if ($urandom_range(1)) begin
        // small alphabet makes self-overlapping patterns likely
        for (k = 0; k < 8; k++) pat[8*k +: 8] = 8'h41 + 8'($urandom_range(2));
      end else begin
        pat = {$urandom, $urandom};
      end
      repl = {$urandom, $urandom};
      if (phase == 1) pat = '0;
      if (phase == 2) pat = '1;
      write_config(pat, plen, repl, rlen);
      queue_random_texts(30, $urandom_range(3) == 0);
      drain();
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/spr_pkg.sv
rtl/spr_cfg_regs.sv
rtl/spr_datapath.sv
rtl/spr_ctrl.sv
rtl/stream_pattern_replace.sv
dv/stream_pattern_replace_tb.sv
